>>> rtl/two_level_cache_access_classifier_core_assert.svh
// assertion macros for the cache access classifier
`ifndef TWO_LEVEL_CACHE_ACCESS_CLASSIFIER_CORE_ASSERT_SVH
`define TWO_LEVEL_CACHE_ACCESS_CLASSIFIER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TLC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TLC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define TLC_ASSERT(label, clk, rstn, prop, msg)
`define TLC_ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

>>> rtl/tlc_pkg.sv
// shared types and constants for the cache access classifier
`timescale 1ns / 1ps
package tlc_pkg;
  localparam int unsigned NumRegs = 6;
  localparam logic [2:0] RegL1Off  = 3'd0;
  localparam logic [2:0] RegL1Idx  = 3'd1;
  localparam logic [2:0] RegL1Ways = 3'd2;
  localparam logic [2:0] RegL2Off  = 3'd3;
  localparam logic [2:0] RegL2Idx  = 3'd4;
  localparam logic [2:0] RegL2Ways = 3'd5;

  localparam logic [1:0] OutReadHit   = 2'd0;
  localparam logic [1:0] OutReadMiss  = 2'd1;
  localparam logic [1:0] OutWriteHit  = 2'd2;
  localparam logic [1:0] OutWriteMiss = 2'd3;

  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0] l1_outcome;
    logic [1:0] l2_outcome;
    logic       memory_write;
  } rsp_t;
endpackage

>>> rtl/tlc_req_if.sv
// valid/ready channel carrying one access
`timescale 1ns / 1ps
interface tlc_req_if;
  logic          valid;
  logic          ready;
  tlc_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tlc_rsp_if.sv
// valid/ready channel carrying one classification result
`timescale 1ns / 1ps
interface tlc_rsp_if;
  logic          valid;
  logic          ready;
  tlc_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/tlc_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module tlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> rtl/two_level_cache_access_classifier_core.sv
// two-level cache access classifier: sequencer over tag rams
// after reset a clear pass sweeps the rams before any access is taken
// per access: each way probed passes through the shared tag compare, plus fixed steps;
//   probing stops at the first hit, and an L2 read hit adds the L1 eviction path
// one access in flight; a finished result waits in the output register while the next is taken
// reset (rst_ni low, async) clears control, registers to defaults, then sweeps the rams
`timescale 1ns / 1ps
`include "two_level_cache_access_classifier_core_assert.svh"
module two_level_cache_access_classifier_core #(
  parameter int unsigned L1_MAX_SETS   = 256,
  parameter int unsigned L1_MAX_WAYS   = 8,
  parameter int unsigned L2_MAX_SETS   = 1024,
  parameter int unsigned L2_MAX_WAYS   = 16,
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [4:0]  cfg_wdata_i,
  tlc_req_if.sink     req,
  tlc_rsp_if.source   rsp
);
  localparam int unsigned L1SB = (L1_MAX_SETS > 1) ? $clog2(L1_MAX_SETS) : 1;
  localparam int unsigned L1WB = (L1_MAX_WAYS > 1) ? $clog2(L1_MAX_WAYS) : 1;
  localparam int unsigned L2SB = (L2_MAX_SETS > 1) ? $clog2(L2_MAX_SETS) : 1;
  localparam int unsigned L2WB = (L2_MAX_WAYS > 1) ? $clog2(L2_MAX_WAYS) : 1;
  localparam int unsigned L1Lim = $clog2(L1_MAX_SETS + 1) - 1;  // floor log2
  localparam int unsigned L2Lim = $clog2(L2_MAX_SETS + 1) - 1;
  localparam int unsigned L1AB = L1SB + L1WB;
  localparam int unsigned L2AB = L2SB + L2WB;
  localparam int unsigned AB = (L1AB > L2AB) ? L1AB : L2AB;
  localparam int unsigned CntB = AB + 1;
  localparam int unsigned TagB = ADDRESS_WIDTH;
  localparam int unsigned LineB = TagB + 2;   // {tag, valid, dirty}
  localparam int unsigned PtrB = (L1WB > L2WB) ? L1WB : L2WB;
  localparam int unsigned WCntB = PtrB + 1;

  typedef enum logic [3:0] {
    StClear, StIdle, StSetup, StPtrRd, StProbe, StProbeWait, StDecide,
    StAlloc, StVicRd, StVicWait, StVicDo, StDone
  } state_e;

  // sub-operations of the access sequence
  typedef enum logic [2:0] {
    OpL1Read, OpL2Read, OpEvict, OpL2Write, OpL1Reread, OpL1Write, OpL2WriteOnly
  } op_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [3:0] l1_off_q, l1_idx_q, l1_ways_q, l2_off_q, l2_idx_q;
  logic [4:0] l2_ways_q;

  tlc_pkg::req_t req_q;
  tlc_pkg::rsp_t rsp_q, rsp_d;            // output register
  tlc_pkg::rsp_t res_q, res_d;            // result being built
  logic          rsp_valid_q, rsp_valid_d;

  logic [CntB-1:0]  clr_q, clr_d;
  logic [WCntB-1:0] way_q, way_d;          // probe counter
  logic [WCntB-1:0] inv_q, inv_d;          // first invalid way, or ways when none
  logic             hit_q, hit_d;
  logic [PtrB-1:0]  hway_q, hway_d;
  logic             lvl2_q, lvl2_d;        // current level of the shared unit
  logic             evdirty_q, evdirty_d;
  logic [PtrB-1:0]  vic_q, vic_d;

  // level geometry
  logic [3:0]       off_sel, idxs;
  logic [4:0]       ways_raw;
  logic [WCntB-1:0] ways_n;
  logic [TagB-1:0]  addr;
  logic [TagB-1:0]  shifted;
  logic [AB-1:0]    set_idx;
  logic [TagB-1:0]  tag;
  logic [5:0]       tsh;

  always_comb begin
    logic [3:0] lim;
    logic [5:0] maxw;
    addr = TagB'(req_q.address);
    off_sel = lvl2_q ? l2_off_q : l1_off_q;
    lim = lvl2_q ? 4'(L2Lim) : 4'(L1Lim);
    idxs = lvl2_q ? l2_idx_q : l1_idx_q;
    if (idxs > lim) idxs = lim;
    ways_raw = lvl2_q ? l2_ways_q : {1'b0, l1_ways_q};
    maxw = lvl2_q ? 6'(L2_MAX_WAYS) : 6'(L1_MAX_WAYS);
    if (ways_raw == '0) ways_raw = 5'd1;
    if ({1'b0, ways_raw} > maxw) ways_n = WCntB'(maxw);
    else ways_n = WCntB'(ways_raw);
    shifted = addr >> off_sel;
    set_idx = AB'(shifted & ((TagB'(1) << idxs) - TagB'(1)));
    tsh = 6'(off_sel) + 6'(idxs);
    // a shift past the address width leaves a zero tag
    tag = addr >> tsh;
  end

  // rams
  logic             l1_we, l2_we, p1_we, p2_we;
  logic [L1AB-1:0]  l1_addr;
  logic [L2AB-1:0]  l2_addr;
  logic [LineB-1:0] line_wd, l1_rd, l2_rd;
  logic [L1SB-1:0]  p1_addr;
  logic [L2SB-1:0]  p2_addr;
  logic [PtrB-1:0]  ptr_wd;
  logic [L1WB-1:0]  p1_rd;
  logic [L2WB-1:0]  p2_rd;

  tlc_ram #(.Width(LineB), .Depth(L1_MAX_SETS * L1_MAX_WAYS)) u_l1_lines (
    .clk_i, .we_i(l1_we), .addr_i(l1_addr), .wdata_i(line_wd), .rdata_o(l1_rd));
  tlc_ram #(.Width(LineB), .Depth(L2_MAX_SETS * L2_MAX_WAYS)) u_l2_lines (
    .clk_i, .we_i(l2_we), .addr_i(l2_addr), .wdata_i(line_wd), .rdata_o(l2_rd));
  tlc_ram #(.Width(L1WB), .Depth(L1_MAX_SETS)) u_l1_ptrs (
    .clk_i, .we_i(p1_we), .addr_i(p1_addr), .wdata_i(L1WB'(ptr_wd)), .rdata_o(p1_rd));
  tlc_ram #(.Width(L2WB), .Depth(L2_MAX_SETS)) u_l2_ptrs (
    .clk_i, .we_i(p2_we), .addr_i(p2_addr), .wdata_i(L2WB'(ptr_wd)), .rdata_o(p2_rd));

  logic [LineB-1:0] line_rd;
  logic [PtrB-1:0]  ptr_rd;
  logic [PtrB-1:0]  wsel;          // way addressed this cycle
  logic             we_line, we_ptr;
  logic             clearing;
  logic [PtrB-1:0]  ptr_q, ptr_d;  // victim pointer of the set
  logic [PtrB-1:0]  vnext, vcur;

  assign line_rd = lvl2_q ? l2_rd : l1_rd;
  assign ptr_rd = lvl2_q ? PtrB'(p2_rd) : PtrB'(p1_rd);
  assign clearing = (state_q == StClear);

  // round robin step on the stored pointer
  always_comb begin
    vcur = ({1'b0, ptr_q} >= ways_n) ? '0 : ptr_q;
    if (({1'b0, vcur} + WCntB'(1)) >= ways_n) vnext = '0;
    else vnext = PtrB'({1'b0, vcur} + WCntB'(1));
  end

  always_comb begin
    l1_addr = clearing ? L1AB'(clr_q) :
              L1AB'({L1SB'(set_idx), L1WB'(wsel)});
    l2_addr = clearing ? L2AB'(clr_q) :
              L2AB'({L2SB'(set_idx), L2WB'(wsel)});
    p1_addr = clearing ? L1SB'(clr_q) : L1SB'(set_idx);
    p2_addr = clearing ? L2SB'(clr_q) : L2SB'(set_idx);
    l1_we = clearing ? (clr_q < CntB'(L1_MAX_SETS * L1_MAX_WAYS)) : (we_line && !lvl2_q);
    l2_we = clearing ? 1'b1 : (we_line && lvl2_q);
    p1_we = clearing ? (clr_q < CntB'(L1_MAX_SETS)) : (we_ptr && !lvl2_q);
    p2_we = clearing ? (clr_q < CntB'(L2_MAX_SETS)) : (we_ptr && lvl2_q);
  end

  // the output register parts the two sides: a waiting result does not block the input
  assign req.ready = (state_q == StIdle);
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;

  logic hit_now;
  assign hit_now = line_rd[1] && (line_rd[LineB-1:2] == tag);

  always_comb begin
    state_d = state_q; op_d = op_q; clr_d = clr_q; way_d = way_q; inv_d = inv_q;
    hit_d = hit_q; hway_d = hway_q; lvl2_d = lvl2_q; evdirty_d = evdirty_q;
    vic_d = vic_q; ptr_d = ptr_q; rsp_d = rsp_q; rsp_valid_d = rsp_valid_q;
    res_d = res_q;
    wsel = PtrB'(way_q); we_line = 1'b0; we_ptr = 1'b0; line_wd = '0; ptr_wd = '0;
    if (rsp.ready && rsp_valid_q) rsp_valid_d = 1'b0;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + CntB'(1);
        if (clr_q == CntB'(L2_MAX_SETS * L2_MAX_WAYS - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (req.valid && req.ready) begin
          res_d = '0;
          lvl2_d = 1'b0;
          op_d = (req.payload.action == tlc_pkg::ActWrite) ? OpL1Write : OpL1Read;
          state_d = StSetup;
        end
      end
      StSetup: begin
        // start a search on the current level, pointer read issued too
        way_d = '0; inv_d = ways_n; hit_d = 1'b0;
        state_d = StPtrRd;
      end
      StPtrRd: begin
        // pointer ram read data arrives next cycle; first line read issued
        state_d = StProbe;
        way_d = '0;
      end
      StProbe: begin
        ptr_d = ptr_rd;
        if (op_q == OpEvict) begin
          state_d = StVicRd;
        end else begin
          state_d = StProbeWait;
        end
      end
      StProbeWait: begin
        // line of way_q valid on line_rd now (issued last cycle at same way)
        if (!hit_q && hit_now) begin
          hit_d = 1'b1; hway_d = PtrB'(way_q);
        end
        if (!line_rd[1] && inv_q == ways_n) inv_d = way_q;
        if (way_q + WCntB'(1) >= ways_n || (!hit_q && hit_now)) begin
          state_d = StDecide;
        end else begin
          way_d = way_q + WCntB'(1);
          state_d = StProbe;
        end
      end
      StDecide: begin
        unique case (op_q)
          OpL1Read, OpL2Read, OpL1Reread: begin
            if (hit_q) begin
              if (op_q == OpL2Read) begin
                lvl2_d = 1'b0; op_d = OpEvict; state_d = StSetup;
              end else begin
                state_d = StDone;
              end
            end else begin
              state_d = StAlloc;
            end
            if (op_q == OpL1Read) begin
              res_d.l1_outcome = hit_q ? tlc_pkg::OutReadHit : tlc_pkg::OutReadMiss;
            end
            if (op_q == OpL2Read) begin
              res_d.l2_outcome = hit_q ? tlc_pkg::OutReadHit : tlc_pkg::OutReadMiss;
            end
          end
          OpL1Write: begin
            res_d.l1_outcome = hit_q ? tlc_pkg::OutWriteHit : tlc_pkg::OutWriteMiss;
            if (hit_q) state_d = StAlloc;
            else begin
              lvl2_d = 1'b1; op_d = OpL2WriteOnly; state_d = StSetup;
            end
          end
          OpL2WriteOnly: begin
            res_d.l2_outcome = hit_q ? tlc_pkg::OutWriteHit : tlc_pkg::OutWriteMiss;
            res_d.memory_write = !hit_q;
            state_d = hit_q ? StAlloc : StDone;
          end
          OpL2Write: begin
            state_d = hit_q ? StAlloc : StVicDo;
            if (!hit_q) lvl2_d = 1'b0;
          end
          default: state_d = StDone;
        endcase
      end
      StAlloc: begin
        // write phase of the shared unit
        if (op_q == OpL1Write || op_q == OpL2WriteOnly || op_q == OpL2Write) begin
          wsel = hway_q;
          we_line = 1'b1;
          line_wd = {tag, 1'b1, 1'b1};
          if (op_q == OpL2Write) begin
            state_d = StVicDo; lvl2_d = 1'b0;
          end else begin
            state_d = StDone;
          end
        end else begin
          if (inv_q < ways_n) begin
            wsel = PtrB'(inv_q);
          end else begin
            wsel = vcur; we_ptr = 1'b1; ptr_wd = vnext;
          end
          we_line = 1'b1;
          line_wd = {tag, 1'b1, 1'b0};
          if (op_q == OpL1Read) begin
            lvl2_d = 1'b1; op_d = OpL2Read; state_d = StSetup;
          end else begin
            state_d = StDone;
          end
        end
      end
      StVicRd: begin
        // victim way chosen and pointer advanced; read its line
        vic_d = vcur;
        we_ptr = 1'b1; ptr_wd = vnext;
        wsel = vcur;
        state_d = StVicWait;
      end
      StVicWait: begin
        wsel = vic_q;
        state_d = StVicDo;
        evdirty_d = 1'b1;
      end
      StVicDo: begin
        wsel = vic_q;
        if (evdirty_q) begin
          // first pass: data of the victim line is on the read port
          evdirty_d = 1'b0;
          if (line_rd[0]) begin
            lvl2_d = 1'b1; op_d = OpL2Write; state_d = StSetup;
          end else begin
            state_d = StVicDo;
          end
        end else begin
          we_line = 1'b1;
          line_wd = {line_rd[LineB-1:2], 2'b00};
          op_d = OpL1Reread; state_d = StSetup;
        end
      end
      StDone: begin
        // hand over once the output register is free or drains this cycle
        if (!rsp_valid_q || rsp.ready) begin
          rsp_d = res_q;
          rsp_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; op_q <= OpL1Read; clr_q <= '0;
      rsp_valid_q <= 1'b0; rsp_q <= '0; lvl2_q <= 1'b0;
      l1_off_q <= 4'd4; l1_idx_q <= 4'd6; l1_ways_q <= 4'd4;
      l2_off_q <= 4'd4; l2_idx_q <= 4'd8; l2_ways_q <= 5'd8;
    end else begin
      state_q <= state_d; op_q <= op_d; clr_q <= clr_d;
      rsp_valid_q <= rsp_valid_d; rsp_q <= rsp_d; lvl2_q <= lvl2_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tlc_pkg::RegL1Off:  l1_off_q <= cfg_wdata_i[3:0];
          tlc_pkg::RegL1Idx:  l1_idx_q <= cfg_wdata_i[3:0];
          tlc_pkg::RegL1Ways: l1_ways_q <= cfg_wdata_i[3:0];
          tlc_pkg::RegL2Off:  l2_off_q <= cfg_wdata_i[3:0];
          tlc_pkg::RegL2Idx:  l2_idx_q <= cfg_wdata_i[3:0];
          tlc_pkg::RegL2Ways: l2_ways_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && req.valid && req.ready) req_q <= req.payload;
    res_q <= res_d; way_q <= way_d; inv_q <= inv_d; hit_q <= hit_d;
    hway_q <= hway_d; evdirty_q <= evdirty_d; vic_q <= vic_d; ptr_q <= ptr_d;
  end

  // checks
  `TLC_ASSERT(a_no_accept_busy, clk_i, rst_ni,
    (req.valid && req.ready) |-> (state_q == StIdle), "access taken while busy")
  `TLC_ASSERT_NEXT(a_done_valid, clk_i, rst_ni, (state_q == StDone), rsp.valid,
    "result not presented after done")
  `TLC_ASSERT(a_mem_write_only_on_write_miss, clk_i, rst_ni,
    (rsp.valid && rsp.payload.memory_write) |->
      (rsp.payload.l1_outcome == tlc_pkg::OutWriteMiss), "memory write without write miss")
endmodule
